[src/rmr_pkg.sv]
// rmr_pkg: shared codes and types for the rapid move restorer
`timescale 1ns / 1ps

package rmr_pkg;

    // motion-code class of an input line
    localparam logic [2:0] CLS_NONE  = 3'd0;
    localparam logic [2:0] CLS_HOME  = 3'd1;
    localparam logic [2:0] CLS_G0    = 3'd2;
    localparam logic [2:0] CLS_G1    = 3'd3;
    localparam logic [2:0] CLS_OTHER = 3'd4;

    // speed override command
    localparam logic [1:0] OVR_NONE   = 2'd0;
    localparam logic [1:0] OVR_LOCK   = 2'd1;
    localparam logic [1:0] OVR_UNLOCK = 2'd2;

    // modal motion mode kept between lines
    typedef enum logic [1:0] {
        LM_NONE  = 2'd0,
        LM_G0    = 2'd1,
        LM_G1    = 2'd2,
        LM_OTHER = 2'd3
    } motion_t;

    // rewrite codes of a result
    typedef enum logic [2:0] {
        RW_KEEP     = 3'd0,
        RW_RAPID_Z  = 3'd1,
        RW_RAPID_XY = 3'd2,
        RW_FEED_XYZ = 3'd3,
        RW_FEED_Z   = 3'd4,
        RW_FEED_XY  = 3'd5
    } rewrite_t;

    // control state flags
    typedef struct packed {
        motion_t last_motion;
        logic    z_current_valid;
        logic    z_previous_valid;
        logic    z_feed_valid;
        logic    z_feed_settled;
        logic    feed_needed;
        logic    speed_locked;
    } flags_t;

    // control part of one result
    typedef struct packed {
        rewrite_t rewrite;
        logic     feed_appended;
        logic     rapid_group;
    } res_ctrl_t;

endpackage

[src/rmr_if.sv]
// rmr_if: valid/ready channels for parsed lines and rewrite results
`timescale 1ns / 1ps

interface rmr_line_if #(
    parameter int COORD_WIDTH = 28,
    parameter int FEED_WIDTH  = 30
);
    logic                          valid;
    logic                          ready;
    logic [2:0]                    gcode_class;
    logic [1:0]                    override_cmd;
    logic                          has_z;
    logic signed [COORD_WIDTH-1:0] z_value;
    logic                          has_xy;
    logic                          has_feed;
    logic [FEED_WIDTH-1:0]         feed_value;

    modport source (
        output valid, gcode_class, override_cmd, has_z, z_value, has_xy, has_feed,
               feed_value,
        input  ready
    );
    modport sink (
        input  valid, gcode_class, override_cmd, has_z, z_value, has_xy, has_feed,
               feed_value,
        output ready
    );
endinterface

interface rmr_result_if #(
    parameter int COORD_WIDTH = 28,
    parameter int FEED_WIDTH  = 30
);
    logic                          valid;
    logic                          ready;
    logic [2:0]                    rewrite;
    logic                          feed_appended;
    logic                          rapid_group;
    logic signed [COORD_WIDTH-1:0] out_z;
    logic [FEED_WIDTH-1:0]         out_feed;

    modport source (
        output valid, rewrite, feed_appended, rapid_group, out_z, out_feed,
        input  ready
    );
    modport sink (
        input  valid, rewrite, feed_appended, rapid_group, out_z, out_feed,
        output ready
    );
endinterface

[src/rapid_move_restorer.sv]
// rapid_move_restorer: top level with line register, state and result stage
`timescale 1ns / 1ps

// Takes one parsed motion line per transfer on motion and returns exactly one
// rewrite decision per line on decision, in order. A line is captured in an
// input register, where the decision logic evaluates it against the kept
// modal state; once the result register has room, that state is updated and
// the result register is loaded with the decision. One line is taken every
// cycle while decision accepts results; the rate is set by the state update
// loop, which closes through the decision logic.
// Backpressure on decision stalls the input register only once the result
// register is full.

module rapid_move_restorer
    import rmr_pkg::*;
#(
    parameter int COORD_WIDTH = 28,
    parameter int FEED_WIDTH  = 30
) (
    input  logic         clk,
    input  logic         rst_n,
    rmr_line_if.sink     motion,
    rmr_result_if.source decision
);

    // input register
    logic                          in_valid_reg;
    logic [2:0]                    cls_reg;
    logic [1:0]                    ovr_reg;
    logic                          has_z_reg;
    logic signed [COORD_WIDTH-1:0] z_value_reg;
    logic                          has_xy_reg;
    logic                          has_feed_reg;
    logic [FEED_WIDTH-1:0]         feed_value_reg;

    // kept state
    flags_t                        flags_reg;
    flags_t                        flags_next;
    logic signed [COORD_WIDTH-1:0] z_current_reg;
    logic signed [COORD_WIDTH-1:0] z_current_next;
    logic signed [COORD_WIDTH-1:0] z_previous_reg;
    logic signed [COORD_WIDTH-1:0] z_previous_next;
    logic signed [COORD_WIDTH-1:0] z_feed_level_reg;
    logic signed [COORD_WIDTH-1:0] z_feed_level_next;
    logic [FEED_WIDTH-1:0]         feed_rate_reg;
    logic [FEED_WIDTH-1:0]         feed_rate_next;

    res_ctrl_t                     res_ctrl;
    logic signed [COORD_WIDTH-1:0] res_z;
    logic [FEED_WIDTH-1:0]         res_feed;
    logic                          out_free;
    logic                          advance;
    logic                          take;

    // the registered line moves on when the result register has room
    assign advance      = in_valid_reg && out_free;
    assign motion.ready = !in_valid_reg || out_free;
    assign take         = motion.valid && motion.ready;

    // input valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    // input payload capture
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cls_reg        <= motion.gcode_class;
            ovr_reg        <= motion.override_cmd;
            has_z_reg      <= motion.has_z;
            z_value_reg    <= motion.z_value;
            has_xy_reg     <= motion.has_xy;
            has_feed_reg   <= motion.has_feed;
            feed_value_reg <= motion.feed_value;
        end
    end

    rmr_decide #(
        .COORD_WIDTH (COORD_WIDTH),
        .FEED_WIDTH  (FEED_WIDTH)
    ) u_decide (
        .gcode_class       (cls_reg),
        .override_cmd      (ovr_reg),
        .has_z             (has_z_reg),
        .z_value           (z_value_reg),
        .has_xy            (has_xy_reg),
        .has_feed          (has_feed_reg),
        .feed_value        (feed_value_reg),
        .flags             (flags_reg),
        .z_current         (z_current_reg),
        .z_previous        (z_previous_reg),
        .z_feed_level      (z_feed_level_reg),
        .feed_rate         (feed_rate_reg),
        .flags_next        (flags_next),
        .z_current_next    (z_current_next),
        .z_previous_next   (z_previous_next),
        .z_feed_level_next (z_feed_level_next),
        .feed_rate_next    (feed_rate_next),
        .res_ctrl          (res_ctrl),
        .res_z             (res_z),
        .res_feed          (res_feed)
    );

    // modal state update, once per line
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg        <= '0;
            z_current_reg    <= '0;
            z_previous_reg   <= '0;
            z_feed_level_reg <= '0;
            feed_rate_reg    <= '0;
        end
        else if (advance)
        begin
            flags_reg        <= flags_next;
            z_current_reg    <= z_current_next;
            z_previous_reg   <= z_previous_next;
            z_feed_level_reg <= z_feed_level_next;
            feed_rate_reg    <= feed_rate_next;
        end
    end

    rmr_out_stage #(
        .COORD_WIDTH (COORD_WIDTH),
        .FEED_WIDTH  (FEED_WIDTH)
    ) u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (advance),
        .res_ctrl (res_ctrl),
        .res_z    (res_z),
        .res_feed (res_feed),
        .free     (out_free),
        .result   (decision)
    );

endmodule

[src/rmr_decide.sv]
// rmr_decide: rewrite decision and next state for one registered line
`timescale 1ns / 1ps

module rmr_decide
    import rmr_pkg::*;
#(
    parameter int COORD_WIDTH = 28,
    parameter int FEED_WIDTH  = 30
) (
    input  logic [2:0]                    gcode_class,
    input  logic [1:0]                    override_cmd,
    input  logic                          has_z,
    input  logic signed [COORD_WIDTH-1:0] z_value,
    input  logic                          has_xy,
    input  logic                          has_feed,
    input  logic [FEED_WIDTH-1:0]         feed_value,
    input  flags_t                        flags,
    input  logic signed [COORD_WIDTH-1:0] z_current,
    input  logic signed [COORD_WIDTH-1:0] z_previous,
    input  logic signed [COORD_WIDTH-1:0] z_feed_level,
    input  logic [FEED_WIDTH-1:0]         feed_rate,
    output flags_t                        flags_next,
    output logic signed [COORD_WIDTH-1:0] z_current_next,
    output logic signed [COORD_WIDTH-1:0] z_previous_next,
    output logic signed [COORD_WIDTH-1:0] z_feed_level_next,
    output logic [FEED_WIDTH-1:0]         feed_rate_next,
    output res_ctrl_t                     res_ctrl,
    output logic signed [COORD_WIDTH-1:0] res_z,
    output logic [FEED_WIDTH-1:0]         res_feed
);

    localparam logic signed [COORD_WIDTH-1:0] ZMAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};

    flags_t                        f;
    logic signed [COORD_WIDTH-1:0] zc;
    logic signed [COORD_WIDTH-1:0] zp;
    logic signed [COORD_WIDTH-1:0] zf;
    logic [FEED_WIDTH-1:0]         fr;
    rewrite_t                      rw;
    logic                          app;
    logic                          no_motion;
    logic                          up;

    always_comb
    begin
        f         = flags;
        zc        = z_current;
        zp        = z_previous;
        zf        = z_feed_level;
        fr        = feed_rate;
        rw        = RW_KEEP;
        app       = 1'b0;
        up        = 1'b0;
        no_motion = !(gcode_class == CLS_G0 || gcode_class == CLS_G1 ||
                      gcode_class == CLS_OTHER);

        // override lock
        if (override_cmd == OVR_LOCK)
        begin
            f.speed_locked = 1'b1;
        end
        else if (override_cmd == OVR_UNLOCK)
        begin
            f.speed_locked = 1'b0;
        end

        if (gcode_class != CLS_HOME)
        begin
            // modal motion mode
            if (!no_motion)
            begin
                if (gcode_class == CLS_G0)
                begin
                    f.last_motion = LM_G0;
                    f.feed_needed = 1'b0;
                end
                else if (gcode_class == CLS_G1)
                begin
                    f.last_motion = LM_G1;
                end
                else
                begin
                    f.last_motion = LM_OTHER;
                end
            end

            // z history and feed rate
            if (has_z)
            begin
                zp                 = zc;
                f.z_previous_valid = f.z_current_valid;
                zc                 = z_value;
                f.z_current_valid  = 1'b1;
            end
            if (has_feed)
            begin
                fr = feed_value;
            end

            // learn the feed height from z-only moves
            if ((!f.z_feed_valid || !f.z_feed_settled) &&
                (f.last_motion == LM_G0 || f.last_motion == LM_G1) && has_z && !has_xy)
            begin
                if (f.z_feed_valid)
                begin
                    f.z_feed_settled = 1'b1;
                end
                zf             = zc;
                f.z_feed_valid = 1'b1;
                if (f.last_motion != LM_G0)
                begin
                    rw            = RW_RAPID_Z;
                    f.feed_needed = 1'b1;
                    f.last_motion = LM_G0;
                end
            end

            // feed move that can become rapid, or rapid going back to cutting
            if (f.last_motion == LM_G1 && !f.speed_locked)
            begin
                if (has_z)
                begin
                    up = (f.z_previous_valid && zc >= zp) ||
                         (f.z_feed_valid && zc >= zf) || fr == '0;
                    if (!has_xy && up)
                    begin
                        rw            = RW_RAPID_Z;
                        f.feed_needed = 1'b1;
                        f.last_motion = LM_G0;
                    end
                end
                else if (f.z_feed_valid && f.z_current_valid && zc >= zf)
                begin
                    rw            = RW_RAPID_XY;
                    f.feed_needed = 1'b1;
                    f.last_motion = LM_G0;
                end
            end
            else if (f.feed_needed && no_motion)
            begin
                if (has_z)
                begin
                    if (has_xy)
                    begin
                        rw            = RW_FEED_XYZ;
                        f.feed_needed = 1'b0;
                        f.last_motion = LM_G1;
                    end
                    else if (f.z_feed_valid && zc < zf && f.z_previous_valid && zc <= zp)
                    begin
                        rw            = RW_FEED_Z;
                        f.feed_needed = 1'b0;
                        f.last_motion = LM_G1;
                    end
                end
                else if (has_xy && f.z_feed_valid && f.z_current_valid && zc < zf)
                begin
                    rw            = RW_FEED_XY;
                    f.feed_needed = 1'b0;
                    f.last_motion = LM_G1;
                end
            end

            // pending feed rate goes onto the next non-rapid line
            if (f.last_motion != LM_G0 && f.feed_needed)
            begin
                app           = !has_feed;
                f.feed_needed = 1'b0;
            end

            // cutting at or above the learned feed height raises it
            if (f.z_current_valid && f.z_feed_valid && zc >= zf &&
                f.last_motion != LM_NONE && f.last_motion != LM_G0 && has_xy &&
                (has_z || f.last_motion != LM_G1))
            begin
                zf = (zc == ZMAX) ? ZMAX : zc + COORD_WIDTH'(1);
            end
        end
    end

    assign flags_next        = f;
    assign z_current_next    = zc;
    assign z_previous_next   = zp;
    assign z_feed_level_next = zf;
    assign feed_rate_next    = fr;

    // result fields, zero where unused
    always_comb
    begin
        res_ctrl.rewrite       = rw;
        res_ctrl.feed_appended = app;
        res_ctrl.rapid_group   = (rw != RW_KEEP || app) && f.last_motion == LM_G0;
        res_z                  = '0;
        res_feed               = '0;
        if (rw == RW_RAPID_Z || rw == RW_FEED_XYZ || rw == RW_FEED_Z)
        begin
            res_z = zc;
        end
        if (rw == RW_FEED_XYZ || rw == RW_FEED_Z || rw == RW_FEED_XY || app)
        begin
            res_feed = fr;
        end
    end

endmodule

[src/rmr_out_stage.sv]
// rmr_out_stage: result register that holds a result until its transfer
`timescale 1ns / 1ps

module rmr_out_stage
    import rmr_pkg::*;
#(
    parameter int COORD_WIDTH = 28,
    parameter int FEED_WIDTH  = 30
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,
    input  res_ctrl_t                     res_ctrl,
    input  logic signed [COORD_WIDTH-1:0] res_z,
    input  logic [FEED_WIDTH-1:0]         res_feed,
    output logic                          free,
    rmr_result_if.source                  result
);

    logic                          valid_reg;
    logic                          valid_next;
    res_ctrl_t                     ctrl_reg;
    logic signed [COORD_WIDTH-1:0] z_reg;
    logic [FEED_WIDTH-1:0]         feed_reg;

    // room for a new result when empty or when the held one leaves now
    assign free = !valid_reg || result.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            valid_next = 1'b0;
        end
    end

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ctrl_reg <= res_ctrl;
            z_reg    <= res_z;
            feed_reg <= res_feed;
        end
    end

    assign result.valid         = valid_reg;
    assign result.rewrite       = ctrl_reg.rewrite;
    assign result.feed_appended = ctrl_reg.feed_appended;
    assign result.rapid_group   = ctrl_reg.rapid_group;
    assign result.out_z         = z_reg;
    assign result.out_feed      = feed_reg;

endmodule
